>>> hw/rtl/cleb_pkg.sv
// Shared types, command codes and defaults for the cursor line edit buffer.
// No dependencies; used by cleb_out_buf and cursor_line_edit_buffer_top.

package cleb_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int FUNC_W = 3;
    localparam int CHAR_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_BACKSPACE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LEFT      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RIGHT     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DELETE    = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_PRINT     = 3'd6;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              end_of_line;
        logic              last;
    } out_item_t;

endpackage

>>> hw/rtl/cleb_out_buf.sv
// Output register stage for result items of the line edit buffer.
// Depends on cleb_pkg for the result item type.

module cleb_out_buf
    import cleb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  out_item_t         push_item,
    output logic              push_ok,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_out,
    output logic              m_end_of_line,
    output logic              m_last
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign push_ok = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (push) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && push_ok) begin
            item_reg <= push_item;
        end
    end

    assign m_valid       = valid_reg;
    assign m_char_out    = item_reg.char_out;
    assign m_end_of_line = item_reg.end_of_line;
    assign m_last        = item_reg.last;

endmodule

>>> hw/rtl/cursor_line_edit_buffer_top.sv
// Top level of the cursor line edit buffer: command sequencer, text memory, counts.
// Depends on cleb_pkg and cleb_out_buf.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid s_ready s_func s_char_in        | in
//  m_      | m_valid m_ready m_char_out m_end_of_line m_last | out
//
// Insert, backspace, ignored and unused codes finish in ST_IDLE; left and right read,
// then write, one byte. Reverse reads, then writes, each swapped pair; delete-all steps
// through each byte before the cursor; print reads, then outputs, each byte in turn.
// Print also waits whenever the output register is full and m_ready is low.
// aresetn is synchronous: it empties the buffer; memory contents are not cleared.

module cursor_line_edit_buffer_top
    import cleb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [CHAR_W-1:0] s_char_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_out,
    output logic              m_end_of_line,
    output logic              m_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LEFT_WR  = 4'd1;
    localparam logic [3:0] ST_RIGHT_WR = 4'd2;
    localparam logic [3:0] ST_REV_RD_I = 4'd3;
    localparam logic [3:0] ST_REV_RD_J = 4'd4;
    localparam logic [3:0] ST_REV_WR_I = 4'd5;
    localparam logic [3:0] ST_REV_WR_J = 4'd6;
    localparam logic [3:0] ST_DEL      = 4'd7;
    localparam logic [3:0] ST_PR_RD    = 4'd8;
    localparam logic [3:0] ST_PR_OUT   = 4'd9;
    localparam logic [3:0] ST_PR_END   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     b_reg, b_next;
    logic [CW-1:0]     a_reg, a_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CHAR_W-1:0] tmp_reg, tmp_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;

    logic [CHAR_W-1:0] text_mem [CAPACITY];
    logic [CHAR_W-1:0] rdata_reg;
    logic              we, re;
    logic [AW-1:0]     wa, ra;
    logic [CHAR_W-1:0] wd;

    logic [CW-1:0] b_dec, a_dec, b_inc, a_inc, i_inc, j_inc, j_dec;
    logic [CW-1:0] slot_left, slot_right, gap, total, pr_addr, j_keep;
    logic          keep;

    logic      push, push_ok;
    out_item_t push_item;

    assign b_dec      = b_reg - ONE_C;
    assign a_dec      = a_reg - ONE_C;
    assign b_inc      = b_reg + ONE_C;
    assign a_inc      = a_reg + ONE_C;
    assign i_inc      = i_reg + ONE_C;
    assign j_inc      = j_reg + ONE_C;
    assign j_dec      = j_reg - ONE_C;
    assign slot_left  = CAP_C - ONE_C - a_reg;
    assign slot_right = CAP_C - a_reg;
    assign total      = b_reg + a_reg;
    assign gap        = CAP_C - total;
    assign pr_addr    = (i_reg < b_reg) ? i_reg : i_reg + gap;
    assign keep       = rdata_reg != ch_reg;
    assign j_keep     = keep ? j_inc : j_reg;

    always_comb begin
        state_next = state_reg;
        b_next     = b_reg;
        a_next     = a_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        tmp_next   = tmp_reg;
        ch_next    = ch_reg;
        we         = 1'b0;
        wa         = '0;
        wd         = '0;
        re         = 1'b0;
        ra         = '0;
        push       = 1'b0;
        push_item  = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_func)
                        FUNC_INSERT: begin
                            if (total != CAP_C) begin
                                we     = 1'b1;
                                wa     = b_reg[AW-1:0];
                                wd     = s_char_in;
                                b_next = b_inc;
                            end
                        end
                        FUNC_BACKSPACE: begin
                            if (b_reg != '0) begin
                                b_next = b_dec;
                            end
                        end
                        FUNC_LEFT: begin
                            if (b_reg != '0) begin
                                re         = 1'b1;
                                ra         = b_dec[AW-1:0];
                                state_next = ST_LEFT_WR;
                            end
                        end
                        FUNC_RIGHT: begin
                            if (a_reg != '0) begin
                                re         = 1'b1;
                                ra         = slot_right[AW-1:0];
                                state_next = ST_RIGHT_WR;
                            end
                        end
                        FUNC_REVERSE: begin
                            if (b_reg > ONE_C) begin
                                i_next     = '0;
                                j_next     = b_dec;
                                state_next = ST_REV_RD_I;
                            end
                        end
                        FUNC_DELETE: begin
                            ch_next = s_char_in;
                            if (b_reg != '0) begin
                                re         = 1'b1;
                                ra         = '0;
                                i_next     = '0;
                                j_next     = '0;
                                state_next = ST_DEL;
                            end
                        end
                        FUNC_PRINT: begin
                            i_next     = '0;
                            state_next = ST_PR_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LEFT_WR: begin
                we         = 1'b1;
                wa         = slot_left[AW-1:0];
                wd         = rdata_reg;
                b_next     = b_dec;
                a_next     = a_inc;
                state_next = ST_IDLE;
            end
            ST_RIGHT_WR: begin
                we         = 1'b1;
                wa         = b_reg[AW-1:0];
                wd         = rdata_reg;
                b_next     = b_inc;
                a_next     = a_dec;
                state_next = ST_IDLE;
            end
            ST_REV_RD_I: begin
                re         = 1'b1;
                ra         = i_reg[AW-1:0];
                state_next = ST_REV_RD_J;
            end
            ST_REV_RD_J: begin
                re         = 1'b1;
                ra         = j_reg[AW-1:0];
                tmp_next   = rdata_reg;
                state_next = ST_REV_WR_I;
            end
            ST_REV_WR_I: begin
                we         = 1'b1;
                wa         = i_reg[AW-1:0];
                wd         = rdata_reg;
                state_next = ST_REV_WR_J;
            end
            ST_REV_WR_J: begin
                we = 1'b1;
                wa = j_reg[AW-1:0];
                wd = tmp_reg;
                if (i_inc < j_dec) begin
                    i_next     = i_inc;
                    j_next     = j_dec;
                    state_next = ST_REV_RD_I;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEL: begin
                if (keep) begin
                    we = 1'b1;
                    wa = j_reg[AW-1:0];
                    wd = rdata_reg;
                end
                j_next = j_keep;
                i_next = i_inc;
                if (i_inc < b_reg) begin
                    re = 1'b1;
                    ra = i_inc[AW-1:0];
                end else begin
                    b_next     = j_keep;
                    state_next = ST_IDLE;
                end
            end
            ST_PR_RD: begin
                if (i_reg == total) begin
                    state_next = ST_PR_END;
                end else begin
                    re         = 1'b1;
                    ra         = pr_addr[AW-1:0];
                    state_next = ST_PR_OUT;
                end
            end
            ST_PR_OUT: begin
                if (push_ok) begin
                    push               = 1'b1;
                    push_item.char_out = rdata_reg;
                    i_next             = i_inc;
                    state_next         = ST_PR_RD;
                end
            end
            ST_PR_END: begin
                if (push_ok) begin
                    push                  = 1'b1;
                    push_item.end_of_line = 1'b1;
                    push_item.last        = 1'b1;
                    b_next                = '0;
                    a_next                = '0;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            b_reg     <= '0;
            a_reg     <= '0;
        end else begin
            state_reg <= state_next;
            b_reg     <= b_next;
            a_reg     <= a_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        tmp_reg <= tmp_next;
        ch_reg  <= ch_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            text_mem[wa] <= wd;
        end
        if (re) begin
            rdata_reg <= text_mem[ra];
        end
    end

    cleb_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .push_item     (push_item),
        .push_ok       (push_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_out    (m_char_out),
        .m_end_of_line (m_end_of_line),
        .m_last        (m_last)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, b_reg} + {1'b0, a_reg}) <= {1'b0, CAP_C})
        else $error("text length exceeds capacity");

    a_rev_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REV_RD_I || state_reg == ST_REV_WR_J) |-> (i_reg < j_reg))
        else $error("reverse indices crossed");

    a_del_compact: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEL) |-> (j_reg <= i_reg && i_reg < b_reg))
        else $error("delete-all write index ahead of read index");

    a_print_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PR_END && push_ok) |=> (b_reg == '0 && a_reg == '0 && m_valid))
        else $error("print end did not empty buffer");

    a_print_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PR_OUT) |-> (i_reg < total))
        else $error("print index beyond text");

endmodule
